>>> rtl/core/prqs_pkg.sv
// Shared types and constants for the priority ready queue scheduler.
`timescale 1ns / 1ps
package prqs_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		REQ_ADD    = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_UPDATE = 3'd2,
		REQ_SCHED  = 3'd3,
		REQ_TICK   = 3'd4,
		REQ_LOCK   = 3'd5,
		REQ_UNLOCK = 3'd6,
		REQ_CLEAR  = 3'd7
	} req_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_PRESENT = 2'd3;

	localparam logic CFG_RUN     = 1'b0;
	localparam logic CFG_PREEMPT = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_PICK   = 2'd3
	} op_t;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] prio;
		logic       ready;
	} entry_t;

	typedef struct packed {
		logic   start;
		op_t    op;
		entry_t ent;
	} eng_cmd_t;

	typedef struct packed {
		logic       done;
		logic [1:0] status;
		logic       hit;
		logic [7:0] hit_id;
	} eng_res_t;

endpackage

>>> rtl/core/prqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module prqs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/prqs_table.sv
// Ready table engine: find, insert, remove, re-place and first-ready search over the RAM.
`timescale 1ns / 1ps
module prqs_table
	import prqs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF,
	parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  eng_cmd_t      cmd,
	output eng_res_t      res,
	output logic [CW-1:0] fill
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_FRD  = 7'b0000010,
		S_FUSE = 7'b0000100,
		S_SRD  = 7'b0001000,
		S_SUSE = 7'b0010000,
		S_INS  = 7'b0100000,
		S_IUSE = 7'b1000000
	} state_t;

	state_t        state_q;
	op_t           op_q;
	entry_t        ent_q;
	logic [CW-1:0] k_q, at_q, fill_q;
	logic          done_q, hit_q;
	logic [1:0]    status_q;
	logic [7:0]    hit_id_q;

	logic [CW-1:0] kp1, km1;
	logic          we, shift;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	assign kp1 = k_q + CW'(1);
	assign km1 = k_q - CW'(1);

	// move the read entry down while it ranks below the one being placed
	assign shift = (rdata.prio < ent_q.prio) ||
		(op_q == OP_UPDATE && rdata.prio == ent_q.prio && km1 >= at_q);

	always_comb begin
		we    = 1'b0;
		waddr = k_q[AW-1:0];
		wdata = ent_q;
		raddr = k_q[AW-1:0];
		unique case (state_q)
			S_SRD:  raddr = kp1[AW-1:0];
			S_INS: begin
				raddr = km1[AW-1:0];
				we    = (k_q == '0);
			end
			S_SUSE: begin
				we    = 1'b1;
				wdata = rdata;
			end
			S_IUSE: begin
				we    = 1'b1;
				wdata = shift ? rdata : ent_q;
			end
			default: ;
		endcase
	end

	prqs_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			done_q   <= 1'b0;
			op_q     <= OP_ADD;
			k_q      <= '0;
			at_q     <= '0;
			status_q <= ST_OK;
			hit_q    <= 1'b0;
			hit_id_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// an empty table answers at once, except for an add
					done_q <= cmd.start && (fill_q == '0) && (cmd.op != OP_ADD);
					if (cmd.start) begin
						op_q     <= cmd.op;
						ent_q    <= cmd.ent;
						k_q      <= '0;
						hit_q    <= 1'b0;
						status_q <= ((fill_q == '0) &&
							(cmd.op == OP_REMOVE || cmd.op == OP_UPDATE)) ? ST_ABSENT : ST_OK;
						if (fill_q != '0) begin
							state_q <= S_FRD;
						end else if (cmd.op == OP_ADD) begin
							state_q <= S_INS;
						end
					end
				end
				S_FRD: state_q <= S_FUSE;
				S_FUSE: begin
					if (op_q == OP_PICK && rdata.ready) begin
						hit_q    <= 1'b1;
						hit_id_q <= rdata.id;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (op_q != OP_PICK && rdata.id == ent_q.id) begin
						at_q <= k_q;
						if (op_q == OP_ADD) begin
							status_q <= ST_PRESENT;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else if (kp1 < fill_q) begin
							state_q <= S_SRD;
						end else if (op_q == OP_REMOVE) begin
							fill_q  <= fill_q - CW'(1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_INS;
						end
					end else if (kp1 == fill_q) begin
						if (op_q == OP_ADD && fill_q != CW'(TABLE_DEPTH)) begin
							k_q     <= fill_q;
							state_q <= S_INS;
						end else begin
							priority case (op_q)
								OP_ADD:  status_q <= ST_FULL;
								OP_PICK: status_q <= ST_OK;
								default: status_q <= ST_ABSENT;
							endcase
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						k_q     <= kp1;
						state_q <= S_FRD;
					end
				end
				S_SRD: state_q <= S_SUSE;
				S_SUSE: begin
					k_q <= kp1;
					if (kp1 < fill_q - CW'(1)) begin
						state_q <= S_SRD;
					end else if (op_q == OP_REMOVE) begin
						fill_q  <= fill_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (k_q == '0) begin
						if (op_q == OP_ADD) begin
							fill_q <= fill_q + CW'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_IUSE;
					end
				end
				S_IUSE: begin
					if (shift) begin
						k_q     <= km1;
						state_q <= S_INS;
					end else begin
						if (op_q == OP_ADD) begin
							fill_q <= fill_q + CW'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res  = '{done: done_q, status: status_q, hit: hit_q, hit_id: hit_id_q};
	assign fill = fill_q;

endmodule

>>> rtl/core/priority_ready_queue_scheduler.sv
// Top level: request handshake, configuration, run state, counters and result register.
//
//   port group   dir  contents
//   s_axis_*     in   request: req_type, task_id, task_priority, ready_flag
//   m_axis_*     out  result: status, switched, current_task, current_valid,
//                     entry_count, tick_total, switch_total, tick_stat
//   cfg_*        in   register write: index 0 run_enable, 1 preempt_enable
//
// One request at a time. A request without table work completes the cycle after its
// transfer, then loads the result register from T_PEND once that register is free.
// Table work walks the entries in the RAM (search walk, then shift walk and insertion
// walk) and reports done to this level before the result is formed.
// No clearing pass after reset; only entries below the fill count are read.
// A result held on m_axis stalls the loading of the next request's result, not its transfer.
`timescale 1ns / 1ps
module priority_ready_queue_scheduler
	import prqs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [2:0] req_type, [10:3] task_id, [18:11] task_priority, [19] ready_flag
	input  logic [23:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] status, [2] switched, [10:3] current_task, [11] current_valid,
	// [16:12] entry_count, [48:17] tick_total, [80:49] switch_total, [112:81] tick_stat
	output logic [119:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic         cfg_data
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_DISP = 4'b0010,
		T_WAIT = 4'b0100,
		T_PEND = 4'b1000
	} tstate_t;

	tstate_t       state_q;
	req_t          req_q;
	entry_t        ent_q;
	logic          run_en_q, pre_en_q, lock_q, run_valid_q;
	logic [7:0]    run_task_q;
	logic [31:0]   tick_q, stat_q, swc_q;
	logic [112:0]  pend_q, out_q;
	logic          out_valid_q;

	eng_cmd_t      cmd;
	eng_res_t      res;
	logic [CW-1:0] fill;

	logic          need_eng, complete, hit_v, sw;
	logic [1:0]    status_n;
	logic [31:0]   tick_n, stat_n, swc_n;
	logic [7:0]    task_n;
	logic          valid_n, lock_n;

	assign s_axis_tready = (state_q == T_IDLE);
	assign cfg_ready     = 1'b1;

	always_comb begin
		unique case (req_q)
			REQ_ADD, REQ_REMOVE, REQ_UPDATE: need_eng = 1'b1;
			REQ_SCHED: need_eng = run_en_q && !lock_q;
			REQ_TICK:  need_eng = run_en_q && pre_en_q && !lock_q;
			default:   need_eng = 1'b0;
		endcase
	end

	always_comb begin
		cmd.start = (state_q == T_DISP) && need_eng;
		cmd.ent   = ent_q;
		unique case (req_q)
			REQ_ADD:    cmd.op = OP_ADD;
			REQ_REMOVE: cmd.op = OP_REMOVE;
			REQ_UPDATE: cmd.op = OP_UPDATE;
			default:    cmd.op = OP_PICK;
		endcase
	end

	prqs_table #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.fill   (fill)
	);

	assign complete = ((state_q == T_DISP) && !need_eng) || ((state_q == T_WAIT) && res.done);
	assign hit_v    = (state_q == T_WAIT) && res.hit;

	always_comb begin
		status_n = ST_OK;
		sw       = 1'b0;
		tick_n   = tick_q;
		stat_n   = stat_q;
		swc_n    = swc_q;
		task_n   = run_task_q;
		valid_n  = run_valid_q;
		lock_n   = lock_q;
		unique case (req_q)
			REQ_ADD, REQ_REMOVE, REQ_UPDATE: status_n = res.status;
			REQ_LOCK:   lock_n = 1'b1;
			REQ_UNLOCK: lock_n = 1'b0;
			REQ_CLEAR: begin
				swc_n  = '0;
				stat_n = '0;
			end
			default: begin
				if (req_q == REQ_TICK && run_en_q) begin
					tick_n = tick_q + 32'd1;
					stat_n = stat_q + 32'd1;
				end
				if (hit_v && (!run_valid_q || run_task_q != res.hit_id)) begin
					sw      = 1'b1;
					task_n  = res.hit_id;
					valid_n = 1'b1;
					swc_n   = swc_q + 32'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			req_q       <= REQ_ADD;
			run_en_q    <= 1'b0;
			pre_en_q    <= 1'b1;
			lock_q      <= 1'b0;
			run_valid_q <= 1'b0;
			run_task_q  <= '0;
			tick_q      <= '0;
			stat_q      <= '0;
			swc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_RUN:     run_en_q <= cfg_data;
					CFG_PREEMPT: pre_en_q <= cfg_data;
				endcase
			end
			if (m_axis_tready && state_q != T_PEND) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (s_axis_tvalid) begin
						req_q   <= req_t'(s_axis_tdata[2:0]);
						ent_q   <= '{id: s_axis_tdata[10:3], prio: s_axis_tdata[18:11],
							ready: s_axis_tdata[19]};
						state_q <= T_DISP;
					end
				end
				T_DISP, T_WAIT: begin
					if (state_q == T_DISP && need_eng) begin
						state_q <= T_WAIT;
					end
					if (complete) begin
						tick_q      <= tick_n;
						stat_q      <= stat_n;
						swc_q       <= swc_n;
						run_task_q  <= task_n;
						run_valid_q <= valid_n;
						lock_q      <= lock_n;
						pend_q      <= {stat_n, swc_n, tick_n, 5'(fill), valid_n, task_n, sw,
							status_n};
						state_q     <= T_PEND;
					end
				end
				T_PEND: begin
					// hold until the result register is free
					if (!out_valid_q || m_axis_tready) begin
						out_q       <= pend_q;
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q};

endmodule
